>>> rtl/unsigned_to_decimal_ascii_top_macros.svh
// Assertion macros used by the conversion side (u2d_back) of the binary-to-decimal converter RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U2D_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/u2d_pkg.sv
// Package for the binary-to-decimal ASCII converter: field widths, constants
// and the converter state type. No dependencies.
package u2d_pkg;

    localparam int unsigned IN_BITS    = 64;
    localparam int unsigned CHAR_BITS  = 6;
    localparam int unsigned COUNT_BITS = 5;
    localparam int unsigned NIB_BITS   = 4;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
    localparam logic [NIB_BITS-1:0]  DAB_LIMIT  = 4'd5;
    localparam logic [NIB_BITS-1:0]  DAB_ADD    = 4'd3;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_EMIT
    } bk_state_t;

endpackage

>>> rtl/u2d_if.sv
// Handshake channels of the binary-to-decimal ASCII converter.
// Depends on u2d_pkg for the payload widths.
interface u2d_in_if;
    logic                          valid;
    logic                          ready;
    logic [u2d_pkg::IN_BITS-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface u2d_out_if;
    logic                            valid;
    logic                            ready;
    logic [u2d_pkg::CHAR_BITS-1:0]   digit_char;
    logic [u2d_pkg::COUNT_BITS-1:0]  digit_count;
    logic                            is_last;

    modport source (output valid, output digit_char, output digit_count, output is_last,
                    input ready);
    modport sink   (input valid, input digit_char, input digit_count, input is_last,
                    output ready);
endinterface

>>> rtl/u2d_front.sv
// Input side of the converter: accepts numbers, keeps the used bits and
// holds them in a two-entry queue for the back end. Depends on u2d_pkg, u2d_if.
module u2d_front #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    u2d_in_if.sink                bin,
    output logic                  q_valid,
    output logic [VALUE_BITS-1:0] q_data,
    input  logic                  q_pop
);
    import u2d_pkg::*;

    logic [VALUE_BITS-1:0] slot_mem [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            fill_reg, fill_next;
    logic                  push;
    logic                  pop;

    assign bin.ready = (fill_reg != 2'd2);
    assign push      = bin.valid && bin.ready;
    assign q_valid   = (fill_reg != 2'd0);
    assign pop       = q_pop && q_valid;
    assign q_data    = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // Only the low VALUE_BITS bits of a number take part in the conversion.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= bin.value[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> rtl/u2d_back.sv
// Conversion side: bit-serial double dabble into BCD, then emission of the
// significant digits as ASCII through an output register. Depends on u2d_pkg, u2d_if.
`include "unsigned_to_decimal_ascii_top_macros.svh"

module u2d_back #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  logic [VALUE_BITS-1:0] q_data,
    output logic                  q_pop,
    u2d_out_if.source             dec
);
    import u2d_pkg::*;

    localparam int unsigned DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int unsigned BCD_W  = DIGITS * NIB_BITS;
    localparam int unsigned CNT_W  = $clog2(DIGITS + 1);
    localparam int unsigned IDX_W  = $clog2(DIGITS);
    localparam int unsigned STEP_W = $clog2(VALUE_BITS);

    bk_state_t                             state_reg, state_next;
    logic [VALUE_BITS-1:0]                 bin_reg, bin_next;
    logic [DIGITS-1:0][NIB_BITS-1:0]       bcd_reg, bcd_next;
    logic [DIGITS-1:0][NIB_BITS-1:0]       bcd_adj;
    logic [STEP_W-1:0]                     step_reg, step_next;
    logic [CNT_W-1:0]                      cnt_reg, cnt_next;
    logic [CNT_W-1:0]                      last_pos;
    logic [IDX_W-1:0]                      idx_reg, idx_next;
    logic                                  out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0]                  out_char_reg, out_char_next;
    logic [COUNT_BITS-1:0]                 out_count_reg, out_count_next;
    logic                                  out_last_reg, out_last_next;
    logic                                  slot_free;
    logic                                  load_out;
    logic                                  conv_done;

    assign slot_free = !out_valid_reg || dec.ready;
    assign conv_done = (step_reg == STEP_W'(VALUE_BITS - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_CONV;
                end
            end
            BK_CONV:
            begin
                if (conv_done)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (slot_free && (idx_reg == '0))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Add-3 adjustment of the current BCD word for the shift-and-add-3 step.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= DAB_LIMIT) ? bcd_reg[i] + DAB_ADD : bcd_reg[i];
        end
    end

    // Datapath and outputs.
    always_comb
    begin
        q_pop          = 1'b0;
        load_out       = 1'b0;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        last_pos       = cnt_reg - CNT_W'(1);
        out_char_next  = out_char_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    bin_next  = q_data;
                    bcd_next  = '0;
                    step_next = '0;
                    cnt_next  = CNT_W'(1);
                end
            end
            BK_CONV:
            begin
                // The top bit shifted out of the BCD word is always zero.
                bcd_next  = BCD_W'({bcd_adj, bin_reg[VALUE_BITS-1]});
                bin_next  = bin_reg << 1;
                step_next = step_reg + STEP_W'(1);
                // The value at most doubles plus one per step, so the digit
                // count can grow by one at most: only the next digit is checked.
                if ((cnt_reg < CNT_W'(DIGITS)) && (bcd_next[cnt_reg[IDX_W-1:0]] != '0))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                last_pos = cnt_next - CNT_W'(1);
                idx_next = last_pos[IDX_W-1:0];
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    load_out       = 1'b1;
                    out_char_next  = ASCII_ZERO + {2'b00, bcd_reg[idx_reg]};
                    out_count_next = COUNT_BITS'(cnt_reg);
                    out_last_next  = (idx_reg == '0);
                    idx_next       = idx_reg - IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (dec.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign dec.valid       = out_valid_reg;
    assign dec.digit_char  = out_char_reg;
    assign dec.digit_count = out_count_reg;
    assign dec.is_last     = out_last_reg;

    always_ff @(posedge clk)
    begin
        bin_reg       <= bin_next;
        bcd_reg       <= bcd_next;
        step_reg      <= step_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        out_char_reg  <= out_char_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `U2D_ASSERT_SAME(a_pop_needs_item, q_pop, q_valid, "queue popped while empty")
    `U2D_ASSERT_SAME(a_count_range, state_reg == BK_EMIT,
        (cnt_reg != '0) && (cnt_reg <= CNT_W'(DIGITS)), "digit count out of range")
    `U2D_ASSERT_NEXT(a_last_ends_run, (state_reg == BK_EMIT) && load_out && (idx_reg == '0),
        (state_reg == BK_IDLE) && dec.is_last && dec.valid, "run did not end on last digit")

endmodule

>>> rtl/unsigned_to_decimal_ascii_top.sv
// Top level of the unsigned binary to decimal ASCII converter.
// Depends on u2d_pkg, u2d_if, u2d_front and u2d_back.
//
//  Channel | Direction | Payload                              | Per transaction
//  --------+-----------+--------------------------------------+--------------------------
//  bin     | in        | value[63:0]                          | one number
//  dec     | out       | digit_char, digit_count, is_last     | one ASCII digit
//
// A number is taken from the queue, converted bit by bit in the bit-serial double dabble
// register, then its significant digits leave one at a time through the output register.
// The single shift-and-add-3 BCD register means that one number converts at a time.
// Reset clears the queue occupancy, the converter state and the output valid flag.
// A stall on dec holds the digit in the output register; the two-entry queue keeps
// accepting numbers on bin until it is full.
module unsigned_to_decimal_ascii_top #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    u2d_in_if.sink     bin,
    u2d_out_if.source  dec
);
    import u2d_pkg::*;

    // Hand-over between the front queue and the converter.
    logic                  q_valid;
    logic [VALUE_BITS-1:0] q_data;
    logic                  q_pop;

    // The front masks each number to VALUE_BITS bits and buffers it, so that
    // new transactions can be taken while the converter is still busy.
    u2d_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .bin     (bin),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    // The back end converts one number and streams its digits, most
    // significant first, without leading zeros; zero gives a single '0'.
    u2d_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .dec     (dec)
    );

endmodule

>>> tb/tb_unsigned_to_decimal_ascii_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the unsigned binary to decimal ASCII converter.
// Depends on u2d_pkg, u2d_if and the unsigned_to_decimal_ascii_top RTL.
module tb_unsigned_to_decimal_ascii_top;

    import u2d_pkg::*;

    // The block is built with its full 64-bit input width.
    localparam int unsigned VALUE_BITS  = 64;
    localparam int          MAX_DIGITS  = 20;
    localparam int          RANDOM_ITEMS = 260;
    localparam int          IDLE_PERCENT = 37;
    // The receiver holds off this long once, so that the input queue fills up.
    localparam int          HOLD_CYCLES  = 700;
    localparam int          HOLD_AT_ITEM = 140;
    // Random items in this window are offered and taken without any idling.
    localparam int          STEADY_FIRST = 190;
    localparam int          STEADY_LAST  = 240;
    // This margin covers the drain of the block after the last owed digit.
    localparam int          DRAIN_CYCLES = 200;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          DIRECTED_ROWS = 20;

    // One expected digit transaction on the dec channel.
    typedef struct packed {
        logic [CHAR_BITS-1:0]  ch;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } digit_t;

    logic clk;
    logic rst_n;

    u2d_in_if  bin_ch ();
    u2d_out_if dec_ch ();

    unsigned_to_decimal_ascii_top #(
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .bin   (bin_ch),
        .dec   (dec_ch)
    );

    // Digits still owed by the block, oldest first, across all numbers in flight.
    digit_t pending_digits [$];
    int     error_count;
    int     numbers_taken;
    int     cycle_count;
    bit     steady;

    // Directed numbers. Where the decimal text is obvious it is typed in and checked
    // as written; an empty string leaves the row to the digit predictor.
    logic [63:0] dir_value [0:DIRECTED_ROWS-1] = '{
        64'd0,
        64'd1,
        64'd9,
        64'd10,
        64'd99,
        64'd100,
        64'd4294967295,
        64'd9223372036854775807,
        64'd9223372036854775808,
        64'd9999999999999999999,
        64'd10000000000000000000,
        64'd12345678901234567890,
        64'd18446744073709551614,
        64'd18446744073709551615,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'd999999,
        64'd1000000,
        64'd7,
        64'd255
    };
    string dir_text [0:DIRECTED_ROWS-1] = '{
        "0",
        "1",
        "9",
        "10",
        "",
        "",
        "4294967295",
        "",
        "9223372036854775808",
        "9999999999999999999",
        "10000000000000000000",
        "12345678901234567890",
        "",
        "18446744073709551615",
        "",
        "",
        "",
        "",
        "",
        "255"
    };

    // The clock runs freely with a period of 10 ns.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Every mismatch is printed on one line and counted.
    task automatic report(input string msg);
        error_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Works out the digit transactions of one number: repeated division by ten gives
    // the digits least significant first, and they are queued most significant first.
    function automatic void append_decimal(input logic [63:0] raw);
        logic [63:0] mask;
        logic [63:0] n;
        logic [3:0]  rev [0:MAX_DIGITS-1];
        int          count;
        digit_t      d;
        mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
        n = raw & mask;
        count = 0;
        do
        begin
            rev[count] = 4'(n % 64'd10);
            n = n / 64'd10;
            count++;
        end
        while (n != 64'd0 && count < MAX_DIGITS);
        for (int k = 0; k < count; k++)
        begin
            d.ch    = ASCII_ZERO + CHAR_BITS'(rev[count - 1 - k]);
            d.count = COUNT_BITS'(count);
            d.last  = (k == count - 1);
            pending_digits.push_back(d);
        end
    endfunction

    // Queues the digits of a decimal string typed into the directed table.
    function automatic void append_text(input string text);
        digit_t d;
        for (int k = 0; k < text.len(); k++)
        begin
            d.ch    = CHAR_BITS'(text[k]);
            d.count = COUNT_BITS'(text.len());
            d.last  = (k == text.len() - 1);
            pending_digits.push_back(d);
        end
    endfunction

    // Random numbers are spread over every digit count: values of random bit length,
    // full-width values, values next to a power of ten, and a few tiny ones.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] pow;
        int          mode;
        int          k;
        mode = $urandom_range(99);
        v = {$urandom, $urandom};
        if (mode < 45)
        begin
            k = $urandom_range(64, 1);
            if (k < 64)
            begin
                v = v & ((64'd1 << k) - 64'd1);
            end
        end
        else if (mode < 65)
        begin
            // The full-width value is kept as it is.
        end
        else if (mode < 90)
        begin
            k = $urandom_range(MAX_DIGITS - 1, 0);
            pow = 64'd1;
            repeat (k) pow = pow * 64'd10;
            // A small offset either side; below zero it wraps to the top of the range.
            v = pow + 64'($urandom_range(6)) - 64'd3;
        end
        else
        begin
            v = 64'($urandom_range(20));
        end
        return v;
    endfunction

    // Offers one number on bin, idling at random first, and waits for the transaction.
    // While idle the payload carries junk, which the block must not take.
    task automatic offer_number(input logic [63:0] v, input string text);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            bin_ch.valid <= 1'b0;
            bin_ch.value <= {$urandom, $urandom};
            @(posedge clk);
        end
        bin_ch.valid <= 1'b1;
        bin_ch.value <= v;
        do
        begin
            @(posedge clk);
        end
        while (!bin_ch.ready);
        // The transaction has taken place at this edge; its digits are now owed.
        if (text.len() > 0)
        begin
            append_text(text);
        end
        else
        begin
            append_decimal(v);
        end
        numbers_taken++;
    endtask

    // Receiver: takes digits with random idling, except during the steady window, and
    // once holds off for a long stretch while the sender keeps offering numbers.
    initial
    begin : digit_receiver
        bit held;
        held = 1'b0;
        dec_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && numbers_taken >= HOLD_AT_ITEM)
            begin
                held = 1'b1;
                dec_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            dec_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Checker: every digit transaction on dec is compared field by field with the
    // oldest digit still owed.
    always @(posedge clk)
    begin : digit_checker
        digit_t want;
        if (rst_n && dec_ch.valid && dec_ch.ready)
        begin
            if (pending_digits.size() == 0)
            begin
                report($sformatf("digit %0d arrived with none owed", dec_ch.digit_char));
            end
            else
            begin
                want = pending_digits.pop_front();
                if (dec_ch.digit_char !== want.ch)
                begin
                    report($sformatf("digit_char got %0d, expected %0d",
                                     dec_ch.digit_char, want.ch));
                end
                if (dec_ch.digit_count !== want.count)
                begin
                    report($sformatf("digit_count got %0d, expected %0d",
                                     dec_ch.digit_count, want.count));
                end
                if (dec_ch.is_last !== want.last)
                begin
                    report($sformatf("is_last got %0d, expected %0d",
                                     dec_ch.is_last, want.last));
                end
            end
        end
    end

    // Watchdog: a run that has not finished well within the limit has hung.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Main sequence: reset, the directed table, a pause until the block has emptied,
    // then the random numbers, and finally the drain and the verdict.
    initial
    begin : stimulus
        error_count   = 0;
        numbers_taken = 0;
        steady        = 1'b0;
        rst_n         = 1'b0;
        bin_ch.valid  = 1'b0;
        bin_ch.value  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            offer_number(dir_value[row], dir_text[row]);
        end

        // The sender pauses until every digit owed so far has come out.
        bin_ch.valid <= 1'b0;
        while (pending_digits.size() != 0)
        begin
            @(posedge clk);
        end

        for (int item = 0; item < RANDOM_ITEMS; item++)
        begin
            steady = (item >= STEADY_FIRST && item <= STEADY_LAST);
            offer_number(random_value(), "");
        end
        steady = 1'b0;
        bin_ch.valid <= 1'b0;

        // The watchdog covers the case in which owed digits never arrive.
        while (pending_digits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/u2d_pkg.sv
rtl/u2d_if.sv
rtl/u2d_front.sv
rtl/u2d_back.sv
rtl/unsigned_to_decimal_ascii_top.sv
tb/tb_unsigned_to_decimal_ascii_top.sv
